### rtl/core/columnar_transposition_cipher_macros.svh
// ----------------------------------------------------------------------------
// Columnar transposition cipher - assertion macros
// Shared concurrent assertion forms for the cipher RTL.
// ----------------------------------------------------------------------------
`ifndef COLUMNAR_TRANSPOSITION_CIPHER_MACROS_SVH
`define COLUMNAR_TRANSPOSITION_CIPHER_MACROS_SVH

// Checked on every clock edge outside reset.
`define CTC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define CTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types, constants and helper functions of the transposition cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ctc_pkg;

  localparam int MAX_LEN     = 48;
  localparam int MAX_COLUMNS = 16;

  localparam int LEN_W   = 6;   // holds 0..MAX_LEN and any grid position (< 64)
  localparam int COL_W   = 5;   // holds 0..31 as written to the columns register
  localparam int RCP_W   = 13;  // reciprocal of the column count, 2^12 scale
  localparam int RCP_SH  = 12;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'd1;

  localparam logic [COL_W-1:0] COLUMNS_RESET = 5'd4;
  localparam logic MODE_ENCRYPT = 1'b0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       overflow;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROWS,
    ST_READ,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // store the accepted input byte
    logic calc;     // compute row count, rewind scan counters
    logic read;     // fetch the cell at the current position
    logic advance;  // step to the next cell
    logic finish;   // grid done, clear message state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_cell;  // the cell now presented is the final one of the grid
  } sts_t;

  // ceil(4096 / c) for c in 1..16; exact for ceil(n / c) with n < 64
  function automatic logic [RCP_W-1:0] col_recip(input logic [COL_W-1:0] c);
    logic [RCP_W-1:0] r;
    case (c)
      5'd1:    r = 13'd4096;
      5'd2:    r = 13'd2048;
      5'd3:    r = 13'd1366;
      5'd4:    r = 13'd1024;
      5'd5:    r = 13'd820;
      5'd6:    r = 13'd683;
      5'd7:    r = 13'd586;
      5'd8:    r = 13'd512;
      5'd9:    r = 13'd456;
      5'd10:   r = 13'd410;
      5'd11:   r = 13'd373;
      5'd12:   r = 13'd342;
      5'd13:   r = 13'd316;
      5'd14:   r = 13'd293;
      5'd15:   r = 13'd274;
      default: r = 13'd256;
    endcase
    return r;
  endfunction

  // Filler letter "XYZWPQ"[v mod 6]; mod 3 by base-4 digit sum, mod 2 from bit 0.
  function automatic logic [7:0] filler_char(input logic [LEN_W-1:0] v);
    logic [3:0] s;
    logic [3:0] r3;
    logic [2:0] m;
    logic [7:0] ch;
    s  = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]);
    r3 = (s >= 4'd6) ? s - 4'd6 : s;
    r3 = (r3 >= 4'd3) ? r3 - 4'd3 : r3;
    m  = (r3[0] == v[0]) ? r3[2:0] : r3[2:0] + 3'd3;
    case (m)
      3'd0:    ch = 8'h58;  // X
      3'd1:    ch = 8'h59;  // Y
      3'd2:    ch = 8'h5A;  // Z
      3'd3:    ch = 8'h57;  // W
      3'd4:    ch = 8'h50;  // P
      default: ch = 8'h51;  // Q
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ctc_dp.sv
// ----------------------------------------------------------------------------
// ctc_dp
// Datapath: config registers, message store, grid geometry and scan counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "columnar_transposition_cipher_macros.svh"

module ctc_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ctc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ctc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire ctc_pkg::in_t                    in_data,
  input  wire ctc_pkg::cmd_t                   cmd,
  output ctc_pkg::sts_t                        sts,
  output ctc_pkg::out_t                        out_data
);

  localparam int LW = ctc_pkg::LEN_W;
  localparam int CW = ctc_pkg::COL_W;

  logic [CW-1:0] columns;
  logic          mode;

  logic [7:0]    mem [ctc_pkg::MAX_LEN];
  logic [LW-1:0] count;
  logic          dropped;

  logic [LW-1:0] rows;
  logic [LW-1:0] pos;
  logic [LW-1:0] inner;
  logic [LW-1:0] outer;

  logic [7:0]    rd_data;
  logic          fill_sel;
  logic [7:0]    fill_ch;
  logic          last_cell;

  logic [CW-1:0] cols_eff;
  logic [LW-1:0] cols_w;
  logic [LW-1:0] inner_max;
  logic [LW-1:0] outer_max;
  logic          inner_end;
  logic          scan_end;
  logic [LW:0]   rows_num;
  logic [ctc_pkg::RCP_W+LW-1:0] rows_prod;
  logic [LW:0]   pos_step;

  // zero columns acts as one, anything past the maximum saturates
  always_comb begin
    if (columns == '0) begin
      cols_eff = CW'(1);
    end else if (columns > CW'(ctc_pkg::MAX_COLUMNS)) begin
      cols_eff = CW'(ctc_pkg::MAX_COLUMNS);
    end else begin
      cols_eff = columns;
    end
  end

  assign cols_w    = LW'(cols_eff);
  // encrypt: inner walks rows, stride is columns; decrypt the other way round
  assign inner_max = mode ? cols_w : rows;
  assign outer_max = mode ? rows : cols_w;
  assign inner_end = (inner == inner_max - LW'(1));
  assign scan_end  = inner_end && (outer == outer_max - LW'(1));
  assign pos_step  = {1'b0, pos} + {1'b0, outer_max};

  assign rows_num  = {1'b0, count} + (LW+1)'(cols_eff) - (LW+1)'(1);
  assign rows_prod = (ctc_pkg::RCP_W+LW)'(rows_num[LW-1:0])
                   * (ctc_pkg::RCP_W+LW)'(ctc_pkg::col_recip(cols_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= ctc_pkg::COLUMNS_RESET;
      mode    <= ctc_pkg::MODE_ENCRYPT;
    end else if (cfg_we) begin
      case (cfg_index)
        ctc_pkg::CFG_COLUMNS: columns <= cfg_data[CW-1:0];
        ctc_pkg::CFG_MODE:    mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (count < LW'(ctc_pkg::MAX_LEN)) begin
        count <= count + LW'(1);
      end else begin
        dropped <= 1'b1;
      end
    end else if (cmd.finish) begin
      count   <= '0;
      dropped <= 1'b0;
    end
  end

  // message store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && (count < LW'(ctc_pkg::MAX_LEN))) begin
      mem[count] <= in_data.in_byte;
    end
    if (cmd.read && (pos < LW'(ctc_pkg::MAX_LEN))) begin
      rd_data <= mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      rows  <= rows_prod[ctc_pkg::RCP_SH +: LW];
      pos   <= '0;
      inner <= '0;
      outer <= '0;
    end else if (cmd.advance) begin
      if (inner_end) begin
        inner <= '0;
        outer <= outer + LW'(1);
        pos   <= outer + LW'(1);
      end else begin
        inner <= inner + LW'(1);
        pos   <= pos_step[LW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      fill_sel  <= (pos >= count);
      fill_ch   <= ctc_pkg::filler_char(pos - count);
      last_cell <= scan_end;
    end
  end

  assign out_data.out_byte = fill_sel ? fill_ch : rd_data;
  assign out_data.out_last = last_cell;
  assign out_data.overflow = dropped;
  assign sts.last_cell     = last_cell;

  `CTC_ASSERT(a_count_bound, clk, rst, count <= LW'(ctc_pkg::MAX_LEN), "count past capacity")
  `CTC_ASSERT(a_drop_full, clk, rst, dropped |-> (count == LW'(ctc_pkg::MAX_LEN)), "room left")
  `CTC_ASSERT(a_rows_nonzero, clk, rst, $past(cmd.calc) |-> (rows != '0), "empty grid computed")

endmodule

`default_nettype wire

### rtl/core/ctc_ctrl.sv
// ----------------------------------------------------------------------------
// ctc_ctrl
// Controller: sequences message load, row computation and grid readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "columnar_transposition_cipher_macros.svh"

module ctc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_last,
  input  wire logic           out_stall,
  input  wire ctc_pkg::sts_t  sts,
  output logic                in_stall,
  output logic                out_valid,
  output ctc_pkg::cmd_t       cmd
);

  ctc_pkg::state_t state;
  ctc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ctc_pkg::ST_IDLE: begin
        if (in_valid && in_last) begin
          state_next = ctc_pkg::ST_ROWS;
        end
      end
      ctc_pkg::ST_ROWS: state_next = ctc_pkg::ST_READ;
      ctc_pkg::ST_READ: state_next = ctc_pkg::ST_OUT;
      ctc_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_next = sts.last_cell ? ctc_pkg::ST_IDLE : ctc_pkg::ST_READ;
        end
      end
      default: state_next = ctc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state)
      ctc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ctc_pkg::ST_ROWS: cmd.calc = 1'b1;
      ctc_pkg::ST_READ: cmd.read = 1'b1;
      ctc_pkg::ST_OUT: begin
        out_valid   = 1'b1;
        cmd.advance = !out_stall && !sts.last_cell;
        cmd.finish  = !out_stall && sts.last_cell;
      end
      default: ;
    endcase
  end

  `CTC_ASSERT(a_last_starts, clk, rst, (in_valid && !in_stall && in_last) |=> (state == ctc_pkg::ST_ROWS), "last byte did not start readout")
  `CTC_ASSERT(a_end_idle, clk, rst, (out_valid && !out_stall && sts.last_cell) |=> !in_stall, "not ready after final cell")
  `CTC_ASSERT(a_hold_out, clk, rst, (out_valid && out_stall) |=> out_valid, "result dropped under stall")

endmodule

`default_nettype wire

### rtl/core/columnar_transposition_cipher.sv
// ----------------------------------------------------------------------------
// columnar_transposition_cipher
// Buffers a message and emits its padded, column-transposed grid.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in       | in_valid / in_stall    | in_data  : in_byte, in_last
//  out      | out_valid / out_stall  | out_data : out_byte, out_last, overflow
//  cfg      | cfg_we                 | cfg_index (0 columns, 1 mode), cfg_data
//
//  Message bytes are taken while idle, the only state with in_stall low. On
//  the last byte the row count is computed, then each grid cell is read through
//  the single read port of the message store and presented from registers. A
//  grid is rows*columns cells, at most len+columns-1; a stalled out request
//  holds its payload and the scan waits with it. Reset (rst, synchronous)
//  empties the message and restores columns=4, encrypt mode; the store
//  itself needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module columnar_transposition_cipher (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // config writes, only between messages or between bytes
  input  wire logic                            cfg_we,
  input  wire logic [ctc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ctc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // message byte requests
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire ctc_pkg::in_t                    in_data,
  // grid byte requests
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output ctc_pkg::out_t                        out_data
);

  ctc_pkg::cmd_t cmd;
  ctc_pkg::sts_t sts;

  // FSM: load -> row count -> (read, present) per cell -> back to load
  ctc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.in_last),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Store, geometry (rows via reciprocal multiply), position counters and
  // filler generation. Positions step by the stride so no divide is needed.
  ctc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
